// ===== rtl/ple_pkg.sv =====
// Shared types, codes and field widths for the positional list engine.
package ple_pkg;

  // Field widths of one request and of one result.
  localparam int CMD_W       = 3;
  localparam int POS_W       = 16;
  localparam int VAL_W       = 32;
  localparam int ST_W        = 3;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  // Request command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_GET    = 3'd3,
    CMD_SHOW   = 3'd4
  } cmd_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_INS_OK    = 3'd0,
    ST_INS_FAIL  = 3'd1,
    ST_DEL_OK    = 3'd2,
    ST_DEL_FAIL  = 3'd3,
    ST_GET_VAL   = 3'd4,
    ST_GET_FAIL  = 3'd5,
    ST_SHOW_ELEM = 3'd6,
    ST_EMPTY     = 3'd7
  } status_t;

  // Next value of the walk pointer.
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_LEN_M1,
    PTR_IDX,
    PTR_IDX_P1,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_sel_t;

  // Memory write source.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DN,
    WR_NEW
  } wr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    ptr_sel_t ptr_sel;
    logic     rd_en;
    wr_sel_t  wr_sel;
    logic     len_inc;
    logic     len_dec;
    logic     out_load;
    status_t  out_status;
    logic     out_rd_data;
    logic     out_last;
  } dp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             pos_ok;
    logic             ins_ok;
    logic             need_up;
    logic             need_dn;
    logic             ptr_eq_idx;
    logic             ptr_eq_lenm1;
    logic             prev_eq_lenm1;
    logic             out_free;
  } dp_stat_t;

endpackage

// ===== rtl/ple_dp.sv =====
// Datapath of the positional list engine: request registers, list memory, walk pointer,
// length counter and result register.
module ple_dp
  import ple_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  dp_ctrl_t               ctrl,
  output dp_stat_t               stat,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  // Captured request.
  logic [CMD_W-1:0] cmd_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;

  // List storage and walk state.
  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_r;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [AW-1:0]    prev_r;
  logic [LW-1:0]    length_r, length_nxt;

  // Result register.
  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic [VAL_W-1:0] out_data_r;
  logic             out_last_r;

  logic [AW-1:0]    idx;
  logic [POS_W:0]   pos_ext;
  logic [POS_W:0]   len_ext;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             out_free;

  // Target slot: head for load, position minus one otherwise.
  assign idx     = (cmd_r == CMD_LOAD) ? '0 : (pos_r[AW-1:0] - AW'(1));
  assign pos_ext = {1'b0, pos_r};
  assign len_ext = (POS_W + 1)'(length_r);
  assign out_free = !out_valid_r || out_tready;

  // Status toward the controller.
  always_comb begin
    stat.cmd           = cmd_r;
    stat.full          = (length_r == LW'(DEPTH));
    stat.empty         = (length_r == '0);
    stat.pos_ok        = (pos_r != '0) && (pos_ext <= len_ext);
    stat.ins_ok        = (length_r != LW'(DEPTH)) &&
                         ((pos_r == POS_W'(1)) || ((pos_r != '0) && (pos_ext <= len_ext)));
    stat.need_up       = (LW'(idx) < length_r);
    stat.need_dn       = ((LW'(idx) + LW'(1)) < length_r);
    stat.ptr_eq_idx    = (ptr_r == idx);
    stat.ptr_eq_lenm1  = ((LW'(ptr_r) + LW'(1)) == length_r);
    stat.prev_eq_lenm1 = ((LW'(prev_r) + LW'(1)) == length_r);
    stat.out_free      = out_free;
  end

  // Pointer update.
  always_comb begin
    case (ctrl.ptr_sel)
      PTR_LEN_M1: ptr_nxt = AW'(length_r - LW'(1));
      PTR_IDX:    ptr_nxt = idx;
      PTR_IDX_P1: ptr_nxt = idx + AW'(1);
      PTR_ZERO:   ptr_nxt = '0;
      PTR_INC:    ptr_nxt = ptr_r + AW'(1);
      PTR_DEC:    ptr_nxt = ptr_r - AW'(1);
      default:    ptr_nxt = ptr_r;
    endcase
  end

  // Memory write: moved entry one slot back or forward, or the new value.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx;
    wr_data = val_r;
    case (ctrl.wr_sel)
      WR_UP: begin
        wr_addr = prev_r + AW'(1);
        wr_data = rd_data_r;
      end
      WR_DN: begin
        wr_addr = prev_r - AW'(1);
        wr_data = rd_data_r;
      end
      WR_NEW: begin
        wr_addr = idx;
        wr_data = val_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Length counter.
  always_comb begin
    length_nxt = length_r;
    if (ctrl.len_inc) begin
      length_nxt = length_r + LW'(1);
    end else if (ctrl.len_dec) begin
      length_nxt = length_r - LW'(1);
    end
  end

  // Request capture, pointers and memory.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r <= in_tdata[CMD_W-1:0];
      pos_r <= in_tdata[CMD_W+POS_W-1:CMD_W];
      val_r <= in_tdata[CMD_W+POS_W+VAL_W-1:CMD_W+POS_W];
    end
    ptr_r <= ptr_nxt;
    if (ctrl.rd_en) begin
      rd_data_r <= mem[ptr_r];
      prev_r    <= ptr_r;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Length and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      length_r <= length_nxt;
      if (ctrl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_status_r <= ctrl.out_status;
      out_data_r   <= ctrl.out_rd_data ? rd_data_r : '0;
      out_last_r   <= ctrl.out_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - VAL_W - ST_W){1'b0}}, out_data_r, out_status_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // The list never grows past its capacity.
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= LW'(DEPTH))
    else $error("list length above capacity");

  // A walk never reads the slot that it writes in the same cycle.
  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.rd_en && wr_en) |-> (wr_addr != ptr_r))
    else $error("read and write hit the same slot");

  // A result is never loaded over one that the receiver has not taken.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overrun");

  // A completed insert adds exactly one entry.
  a_len_inc: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.len_inc |=> (length_r == $past(length_r) + LW'(1)))
    else $error("length did not advance on insert");
`endif

endmodule

// ===== rtl/ple_ctrl.sv =====
// Controller of the positional list engine: sequences each request over the datapath.
module ple_ctrl
  import ple_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP_FIRST,
    S_UP_MID,
    S_UP_LAST,
    S_WR_NEW,
    S_DN_FIRST,
    S_DN_MID,
    S_DN_LAST,
    S_GET_RD,
    S_RESP,
    S_SHOW_RD,
    S_SHOW_WAIT
  } state_t;

  state_t  state_r, state_nxt;
  status_t resp_status_r, resp_status_nxt;
  logic    resp_rd_r, resp_rd_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt       = state_r;
    resp_status_nxt = resp_status_r;
    resp_rd_nxt     = resp_rd_r;
    ctrl             = '0;
    ctrl.ptr_sel     = PTR_HOLD;
    ctrl.wr_sel      = WR_NONE;
    ctrl.out_status  = resp_status_r;
    ctrl.out_rd_data = resp_rd_r;
    ctrl.out_last    = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctrl.capture = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        resp_rd_nxt = 1'b0;
        state_nxt   = S_RESP;
        case (stat.cmd)
          CMD_LOAD, CMD_INSERT: begin
            resp_status_nxt = ST_INS_OK;
            if ((stat.cmd == CMD_LOAD) ? stat.full : !stat.ins_ok) begin
              resp_status_nxt = ST_INS_FAIL;
              state_nxt       = (stat.cmd == CMD_LOAD) ? S_IDLE : S_RESP;
            end else if (stat.need_up) begin
              ctrl.ptr_sel = PTR_LEN_M1;
              state_nxt    = S_UP_FIRST;
            end else begin
              state_nxt = S_WR_NEW;
            end
          end
          CMD_DELETE: begin
            resp_status_nxt = ST_DEL_OK;
            if (!stat.pos_ok) begin
              resp_status_nxt = ST_DEL_FAIL;
            end else if (stat.need_dn) begin
              ctrl.ptr_sel = PTR_IDX_P1;
              state_nxt    = S_DN_FIRST;
            end else begin
              ctrl.len_dec = 1'b1;
            end
          end
          CMD_GET: begin
            resp_status_nxt = ST_GET_FAIL;
            if (stat.pos_ok) begin
              resp_status_nxt = ST_GET_VAL;
              resp_rd_nxt     = 1'b1;
              ctrl.ptr_sel    = PTR_IDX;
              state_nxt       = S_GET_RD;
            end
          end
          CMD_SHOW: begin
            resp_status_nxt = ST_EMPTY;
            if (!stat.empty) begin
              ctrl.ptr_sel = PTR_ZERO;
              state_nxt    = S_SHOW_RD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      // Move entries one slot back, from the tail down to the target slot.
      S_UP_FIRST: begin
        ctrl.rd_en   = 1'b1;
        ctrl.ptr_sel = PTR_DEC;
        state_nxt    = stat.ptr_eq_idx ? S_UP_LAST : S_UP_MID;
      end
      S_UP_MID: begin
        ctrl.wr_sel  = WR_UP;
        ctrl.rd_en   = 1'b1;
        ctrl.ptr_sel = PTR_DEC;
        state_nxt    = stat.ptr_eq_idx ? S_UP_LAST : S_UP_MID;
      end
      S_UP_LAST: begin
        ctrl.wr_sel = WR_UP;
        state_nxt   = S_WR_NEW;
      end
      S_WR_NEW: begin
        ctrl.wr_sel  = WR_NEW;
        ctrl.len_inc = 1'b1;
        state_nxt    = (stat.cmd == CMD_LOAD) ? S_IDLE : S_RESP;
      end
      // Move entries one slot forward, from past the target up to the tail.
      S_DN_FIRST: begin
        ctrl.rd_en   = 1'b1;
        ctrl.ptr_sel = PTR_INC;
        state_nxt    = stat.ptr_eq_lenm1 ? S_DN_LAST : S_DN_MID;
      end
      S_DN_MID: begin
        ctrl.wr_sel  = WR_DN;
        ctrl.rd_en   = 1'b1;
        ctrl.ptr_sel = PTR_INC;
        state_nxt    = stat.ptr_eq_lenm1 ? S_DN_LAST : S_DN_MID;
      end
      S_DN_LAST: begin
        ctrl.wr_sel  = WR_DN;
        ctrl.len_dec = 1'b1;
        state_nxt    = S_RESP;
      end
      S_GET_RD: begin
        ctrl.rd_en = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      // Stream the list, one read in flight behind each loaded result.
      S_SHOW_RD: begin
        ctrl.rd_en   = 1'b1;
        ctrl.ptr_sel = PTR_INC;
        state_nxt    = S_SHOW_WAIT;
      end
      S_SHOW_WAIT: begin
        if (stat.out_free) begin
          ctrl.out_load    = 1'b1;
          ctrl.out_status  = ST_SHOW_ELEM;
          ctrl.out_rd_data = 1'b1;
          ctrl.out_last    = stat.prev_eq_lenm1;
          if (stat.prev_eq_lenm1) begin
            state_nxt = S_IDLE;
          end else begin
            ctrl.rd_en   = 1'b1;
            ctrl.ptr_sel = PTR_INC;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered response selection.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      resp_status_r <= ST_INS_OK;
      resp_rd_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      resp_status_r <= resp_status_nxt;
      resp_rd_r     <= resp_rd_nxt;
    end
  end

endmodule

// ===== rtl/positional_list_engine.sv =====
// Top level of the positional list engine: controller and datapath.
//
// Keeps an ordered list of up to DEPTH signed 32-bit values in a single-port-read,
// single-port-write memory, numbered from position 1 at the head.
// Requests arrive on the in_ channel (load, insert, delete, get, show); results leave
// on the out_ channel, with out_tlast set on the final result of each request.
// One request is handled at a time; in_tready is high only while the engine is idle.
// The time to a result is set by the memory walk, which moves one entry per cycle:
//   insert at position p: the entries from the tail down to p move one slot toward
//   the tail, then the new value is written; load: the same at the head, but
//   with no result; delete at p: the entries past p move one slot toward the head;
//   get: one read; show: one read per entry from the head, one result per cycle
//   without stalls.
// A new request is taken in the cycle after the last result is loaded.
// Results wait in an output register, so a stalled receiver only holds the engine
// while a result is pending; a show pauses its walk until each result is taken.
// Reset (rst_n low, synchronous) empties the list and drops any pending result; the
// memory itself is not cleared, since only written entries are ever read.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // command[2:0], position[18:3], value[50:19]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // status[2:0], data_out[34:3]
  output logic                   out_tlast
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // Sequencer.
  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // Storage, pointers and result register.
  ple_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
